// ===== rtl/mmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcd_pkg
// Shared types and constants of the mouse multi-click detector.
// ----------------------------------------------------------------------------
package mmcd_pkg;

	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [7:0]         WINDOW_RESET = 8'd30;
	localparam logic [15:0]        CLICK_EXTEND = 16'd3;
	localparam logic [15:0]        WAIT_SAT_AT  = 16'd65532;
	localparam logic signed [16:0] MOVE_LIMIT   = 17'sd2;

	// register index as decoded from paddr[2]
	localparam logic REG_WINDOW = 1'b0;

	typedef enum logic [1:0] {
		OP_BUTTON = 2'd0,
		OP_TICK   = 2'd1,
		OP_MOVE   = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [7:0] buttons;
		logic [7:0] clicks;
		logic       last;
	} event_t;

	typedef struct packed {
		logic [1:0] count;
		event_t     ev0;
		event_t     ev1;
	} push_t;

endpackage

// ===== rtl/mmcd_cfg.sv =====
// ----------------------------------------------------------------------------
// mmcd_cfg
// APB register file holding the click window length.
// ----------------------------------------------------------------------------
module mmcd_cfg
	import mmcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [7:0]         window_ticks
);

	logic [7:0] window_q;
	logic       sel_window;

	assign sel_window   = (paddr[2] == REG_WINDOW);
	assign pready       = 1'b1;
	assign window_ticks = window_q;
	assign prdata       = sel_window ? {{(PDATA_W-8){1'b0}}, window_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && sel_window) begin
			window_q <= pwdata[7:0];
		end
	end

endmodule

// ===== rtl/mmcd_core.sv =====
// ----------------------------------------------------------------------------
// mmcd_core
// Input register, click state and event generation, one transaction a cycle while the result queue has room.
// ----------------------------------------------------------------------------
module mmcd_core
	import mmcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        button_state,
	input  logic              multi_click_wanted,
	input  logic [7:0]        tick_amount,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [7:0]        window_ticks,
	input  logic              room,
	output push_t             push
);

	logic              valid_s1;
	logic [1:0]        opcode_s1;
	logic [7:0]        buttons_s1;
	logic              multi_s1;
	logic [7:0]        tick_s1;
	logic signed [15:0] pos_x_s1;
	logic signed [15:0] pos_y_s1;

	logic [7:0]  true_q, desired_q, count_q;
	logic [15:0] wait_q;
	logic [15:0] last_x_q, last_y_q;

	logic [7:0]  true_d, desired_d, count_d;
	logic [15:0] wait_d;
	logic [15:0] last_x_d, last_y_d;

	logic              fire;
	logic              waiting;
	logic              do_expire;
	logic [15:0]       amt;
	logic signed [16:0] dx, dy;
	logic              far;
	push_t             push_d;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;
	assign waiting  = (wait_q != 16'd0);
	assign amt      = {8'd0, tick_s1};
	assign dx       = $signed({last_x_q[15], last_x_q}) - $signed({pos_x_s1[15], pos_x_s1});
	assign dy       = $signed({last_y_q[15], last_y_q}) - $signed({pos_y_s1[15], pos_y_s1});
	assign far      = (dx > MOVE_LIMIT) || (dx < -MOVE_LIMIT)
			|| (dy > MOVE_LIMIT) || (dy < -MOVE_LIMIT);

	always_comb begin
		true_d    = true_q;
		desired_d = desired_q;
		count_d   = count_q;
		wait_d    = wait_q;
		last_x_d  = last_x_q;
		last_y_d  = last_y_q;
		do_expire = 1'b0;
		push_d    = '0;
		case (opcode_t'(opcode_s1))
			OP_BUTTON: begin
				if (buttons_s1 != true_q) begin
					if (waiting) begin
						if (buttons_s1 == desired_q) begin
							if (count_q != 8'hFF) begin
								count_d = count_q + 8'd1;
							end
							wait_d = (wait_q > WAIT_SAT_AT) ? 16'hFFFF : wait_q + CLICK_EXTEND;
						end
					end else if (multi_s1 && buttons_s1 != 8'd0) begin
						count_d   = 8'd1;
						desired_d = buttons_s1;
						wait_d    = (window_ticks == 8'd0) ? 16'd1 : {8'd0, window_ticks};
					end else begin
						push_d.count = 2'd1;
						push_d.ev0   = '{buttons: buttons_s1, clicks: 8'd1, last: 1'b1};
					end
					true_d = buttons_s1;
				end
			end
			OP_TICK: begin
				if (waiting && amt != 16'd0) begin
					if (amt >= wait_q) begin
						do_expire = 1'b1;
					end else begin
						wait_d = wait_q - amt;
					end
				end
			end
			OP_MOVE: begin
				do_expire = waiting && far;
				last_x_d  = pos_x_s1;
				last_y_d  = pos_y_s1;
			end
			default: begin
			end
		endcase
		if (do_expire) begin
			wait_d       = 16'd0;
			push_d.count = (desired_q != true_q) ? 2'd2 : 2'd1;
			push_d.ev0   = '{buttons: desired_q, clicks: count_q, last: (desired_q == true_q)};
			push_d.ev1   = '{buttons: true_q, clicks: 8'd1, last: 1'b1};
		end
		if (!fire) begin
			push_d.count = 2'd0;
		end
	end

	assign push = push_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			true_q    <= '0;
			desired_q <= '0;
			count_q   <= '0;
			wait_q    <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				true_q    <= true_d;
				desired_q <= desired_d;
				count_q   <= count_d;
				wait_q    <= wait_d;
				last_x_q  <= last_x_d;
				last_y_q  <= last_y_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1  <= opcode;
			buttons_s1 <= button_state;
			multi_s1   <= multi_click_wanted;
			tick_s1    <= tick_amount;
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
		end
	end

endmodule

// ===== rtl/mmcd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mmcd_out_fifo
// Result queue taking up to two events per cycle and giving one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module mmcd_out_fifo
	import mmcd_pkg::*;
#(
	parameter int unsigned DEPTH = OUT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] event_buttons,
	output logic [7:0] event_clicks,
	output logic       last
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	event_t        mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q, wptr_nx;
	logic [CW-1:0] count_q;
	logic          pop;
	event_t        head;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wptr_nx       = next_ptr(wptr_q);
	assign pop           = out_valid && out_ready;
	assign room          = (count_q <= CW'(DEPTH - 2));
	assign out_valid     = (count_q != '0);
	assign head          = mem_q[rptr_q];
	assign event_buttons = head.buttons;
	assign event_clicks  = head.clicks;
	assign last          = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			case (push.count)
				2'd1:    wptr_q <= wptr_nx;
				2'd2:    wptr_q <= next_ptr(wptr_nx);
				default: wptr_q <= wptr_q;
			endcase
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wptr_q] <= push.ev0;
		end
		if (push.count == 2'd2) begin
			mem_q[wptr_nx] <= push.ev1;
		end
	end

endmodule

// ===== rtl/mouse_multi_click_detector_top.sv =====
// ----------------------------------------------------------------------------
// mouse_multi_click_detector_top
// Mouse multi-click detector: button, tick and move transactions in,
// button events with click counts out.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    opcode, button_state,
//                                            multi_click_wanted, tick_amount,
//                                            pos_x, pos_y
//   out      output     out_valid/out_ready  event_buttons, event_clicks, last
//   cfg      input      APB psel/penable     click_window_ticks at 0x0
//
// One transaction is accepted per cycle unless the input stalls; it is held in
// the input register, evaluated there, and its zero, one or two events enter
// the result queue when it leaves. The queue is emptied one event per cycle
// while out_ready is high, which holds back transactions giving two events.
// Input stalls while a held transaction waits for two free queue entries.
// Reset clears click state, input valid flag and queue; window resets to 30.
// ----------------------------------------------------------------------------
module mouse_multi_click_detector_top
	import mmcd_pkg::*;
#(
	parameter int unsigned OUT_DEPTH = mmcd_pkg::OUT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [7:0]         button_state,
	input  logic               multi_click_wanted,
	input  logic [7:0]         tick_amount,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         event_buttons,
	output logic [7:0]         event_clicks,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [7:0] window_ticks;
	logic       room;
	push_t      push;

	mmcd_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.window_ticks (window_ticks)
	);

	mmcd_core u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.opcode             (opcode),
		.button_state       (button_state),
		.multi_click_wanted (multi_click_wanted),
		.tick_amount        (tick_amount),
		.pos_x              (pos_x),
		.pos_y              (pos_y),
		.window_ticks       (window_ticks),
		.room               (room),
		.push               (push)
	);

	mmcd_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.room          (room),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_buttons (event_buttons),
		.event_clicks  (event_clicks),
		.last          (last)
	);

endmodule

// ===== rtl/mmcd_checker.sv =====
// ----------------------------------------------------------------------------
// mmcd_checker
// Port-level checks of the mouse multi-click detector, bound to the top.
// ----------------------------------------------------------------------------
module mmcd_checker
	import mmcd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         event_buttons,
	input logic [7:0]         event_clicks,
	input logic               last,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata
);

	logic wr_window;

	assign wr_window = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_buttons)
			&& $stable(event_clicks) && $stable(last))
		else $error("out transaction dropped or changed while stalled");

	a_clicks_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_clicks != 8'd0)
		else $error("event with zero clicks");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && last && event_clicks == 8'd1)
		else $error("multi-click event not followed by single-click current state");

	a_window_readback: assert property (@(posedge clk) disable iff (!arst_n)
		wr_window |=> paddr[2] != REG_WINDOW || prdata[7:0] == $past(pwdata[7:0]))
		else $error("window register readback mismatch");

endmodule

bind mouse_multi_click_detector_top mmcd_checker u_mmcd_checker (.*);

// ===== bench/tb_mouse_multi_click_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_multi_click_detector_top
// Self-checking bench for the mouse multi-click detector. A driver feeds
// button, tick and move transactions from a backlog with random gaps, a
// monitor takes events with random stalls, and a click predictor running on
// every accepted transaction supplies the events the monitor compares against.
// Runs a directed opening, random phases over several window lengths written
// through the APB port, and a run that saturates the click count.
// ----------------------------------------------------------------------------
module tb_mouse_multi_click_detector_top;
	import mmcd_pkg::*;

	localparam time          CLK_PERIOD      = 12ns;
	localparam int           DRAIN_CYCLES    = 12;
	localparam int           PHASE_ITEMS     = 160;
	localparam int           SAT_PAIRS       = 300;
	localparam int           MAX_SHOWN       = 10;
	localparam logic [1:0]   OP_UNUSED       = 2'd3;
	localparam logic [PADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  btn;
		logic        multi;
		logic [7:0]  amt;
		logic [15:0] x;
		logic [15:0] y;
	} mouse_txn_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode;
	logic [7:0]         button_state;
	logic               multi_click_wanted;
	logic [7:0]         tick_amount;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         event_buttons;
	logic [7:0]         event_clicks;
	logic               last;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	mouse_txn_t driven_item = '0;
	mouse_txn_t input_backlog[$];
	event_t     expected_events[$];
	int         inputs_outstanding = 0;
	int         fail_count = 0;
	int         shown_count = 0;
	bit         in_taken = 1'b0;
	bit         calm_in = 1'b0;
	bit         calm_out = 1'b0;
	bit         hold_calm = 1'b0;
	int         gap_left = 0;
	int         stall_left = 0;

	logic [7:0]         window_ticks = WINDOW_RESET;
	logic [7:0]         true_btn = '0;
	logic [7:0]         desired_btn = '0;
	logic [7:0]         click_total = '0;
	logic [15:0]        wait_left = '0;
	logic signed [15:0] last_x = '0;
	logic signed [15:0] last_y = '0;

	logic signed [15:0] walk_x = '0;
	logic signed [15:0] walk_y = '0;

	assign opcode             = driven_item.op;
	assign button_state       = driven_item.btn;
	assign multi_click_wanted = driven_item.multi;
	assign tick_amount        = driven_item.amt;
	assign pos_x              = driven_item.x;
	assign pos_y              = driven_item.y;

	mouse_multi_click_detector_top i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.opcode             (opcode),
		.button_state       (button_state),
		.multi_click_wanted (multi_click_wanted),
		.tick_amount        (tick_amount),
		.pos_x              (pos_x),
		.pos_y              (pos_y),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.event_buttons      (event_buttons),
		.event_clicks       (event_clicks),
		.last               (last),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic predict_events(input mouse_txn_t t);
		event_t produced[$];
		event_t ev;
		bit     closes;
		int     dx;
		int     dy;
		closes = 1'b0;
		case (t.op)
			OP_BUTTON: begin
				if (t.btn != true_btn) begin
					if (wait_left != 0) begin
						if (t.btn == desired_btn) begin
							if (click_total != 8'd255)
								click_total++;
							if (wait_left > WAIT_SAT_AT)
								wait_left = 16'hFFFF;
							else
								wait_left += CLICK_EXTEND;
						end
					end else if (t.multi && t.btn != 8'd0) begin
						click_total = 8'd1;
						desired_btn = t.btn;
						wait_left   = (window_ticks == 8'd0) ? 16'd1 : {8'd0, window_ticks};
					end else begin
						ev = '{buttons: t.btn, clicks: 8'd1, last: 1'b0};
						produced.push_back(ev);
					end
					true_btn = t.btn;
				end
			end
			OP_TICK: begin
				if (wait_left != 0 && t.amt != 8'd0) begin
					if ({8'd0, t.amt} >= wait_left)
						closes = 1'b1;
					else
						wait_left -= {8'd0, t.amt};
				end
			end
			OP_MOVE: begin
				dx = int'(last_x) - int'($signed(t.x));
				dy = int'(last_y) - int'($signed(t.y));
				if (wait_left != 0 && (dx > MOVE_LIMIT || dx < -MOVE_LIMIT ||
						dy > MOVE_LIMIT || dy < -MOVE_LIMIT))
					closes = 1'b1;
				last_x = t.x;
				last_y = t.y;
			end
			default: ;
		endcase
		if (closes) begin
			wait_left = '0;
			ev = '{buttons: desired_btn, clicks: click_total, last: 1'b0};
			produced.push_back(ev);
			if (desired_btn != true_btn) begin
				ev = '{buttons: true_btn, clicks: 8'd1, last: 1'b0};
				produced.push_back(ev);
			end
		end
		if (produced.size() != 0)
			produced[produced.size() - 1].last = 1'b1;
		foreach (produced[i])
			expected_events.push_back(produced[i]);
	endtask

	function automatic int draw_wait(input bit calm);
		return (calm || hold_calm) ? 0 : $urandom_range(0, 10);
	endfunction

	// driver: acceptance and prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_events(driven_item);
			inputs_outstanding--;
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : drive_input
		logic nxt_valid;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (in_valid && !in_taken) begin
			nxt_valid = 1'b1;
		end else if (gap_left != 0) begin
			gap_left--;
			nxt_valid = 1'b0;
		end else if (input_backlog.size() != 0) begin
			driven_item = input_backlog.pop_front();
			nxt_valid = 1'b1;
			if ($urandom_range(0, 39) == 0)
				calm_in = ~calm_in;
			gap_left = draw_wait(calm_in);
		end else begin
			nxt_valid = 1'b0;
		end
		in_taken = 1'b0;
		in_valid <= nxt_valid;
	end

	// monitor
	always @(posedge clk) begin : check_events
		event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				fail_count++;
				if (shown_count < MAX_SHOWN) begin
					shown_count++;
					$display("unexpected event: buttons %h clicks %0d last %b",
						event_buttons, event_clicks, last);
				end
			end else begin
				want = expected_events.pop_front();
				if (event_buttons !== want.buttons || event_clicks !== want.clicks ||
						last !== want.last) begin
					fail_count++;
					if (shown_count < MAX_SHOWN) begin
						shown_count++;
						$display("event mismatch: expected %h/%0d/%b, got %h/%0d/%b",
							want.buttons, want.clicks, want.last,
							event_buttons, event_clicks, last);
					end
				end
			end
			if ($urandom_range(0, 39) == 0)
				calm_out = ~calm_out;
			stall_left = draw_wait(calm_out);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic queue_input(input logic [1:0] op, input logic [7:0] btn, input logic multi,
			input logic [7:0] amt, input logic [15:0] x, input logic [15:0] y);
		mouse_txn_t t;
		t = '{op: op, btn: btn, multi: multi, amt: amt, x: x, y: y};
		input_backlog.push_back(t);
		inputs_outstanding++;
	endtask

	task automatic queue_button(input logic [7:0] btn, input logic multi);
		queue_input(OP_BUTTON, btn, multi, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic queue_tick(input logic [7:0] amt);
		queue_input(OP_TICK, 8'($urandom), 1'($urandom), amt, 16'($urandom),
			16'($urandom));
	endtask

	task automatic queue_move(input logic [15:0] x, input logic [15:0] y);
		walk_x = x;
		walk_y = y;
		queue_input(OP_MOVE, 8'($urandom), 1'($urandom), 8'($urandom), x, y);
	endtask

	task automatic wait_idle();
		while (inputs_outstanding != 0 || expected_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_window(input logic [7:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_WINDOW;
		pwdata  = {{(PDATA_W - 8){1'b0}}, value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		window_ticks = value;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic queue_random_items(input int count);
		logic [7:0] pool[3];
		logic [7:0] btn;
		int         pick;
		pool[0] = 8'($urandom_range(1, 255));
		pool[1] = 8'($urandom);
		pool[2] = 8'd0;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				queue_input(OP_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom),
					16'($urandom), 16'($urandom));
			end else if (pick < 48) begin
				btn = ($urandom_range(0, 7) == 0) ? 8'($urandom) : pool[$urandom_range(0, 2)];
				queue_button(btn, $urandom_range(0, 3) != 0);
			end else if (pick < 80) begin
				queue_tick(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 8)) :
					8'($urandom));
			end else if ($urandom_range(0, 4) != 0) begin
				queue_move(walk_x + 16'($signed($urandom_range(0, 6)) - 3),
					walk_y + 16'($signed($urandom_range(0, 6)) - 3));
			end else begin
				queue_move(16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		#(CLK_PERIOD * 1000000);
		$display("tb_mouse_multi_click_detector_top NOT OK");
		$finish;
	end

	initial begin
		logic [7:0] window_plan[6];
		window_plan = '{8'd1, 8'd0, 8'd255, 8'd0, 8'd30, 8'd6};
		window_plan[3] = 8'($urandom_range(2, 254));
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening, window at its reset length
		queue_input(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
		queue_button(8'h00, 1'b0);
		queue_button(8'hFF, 1'b0);
		queue_button(8'h00, 1'b1);
		queue_button(8'h01, 1'b1);
		queue_tick(8'd0);
		queue_button(8'h00, 1'b0);
		queue_button(8'h01, 1'b0);
		queue_button(8'h00, 1'b1);
		queue_button(8'h01, 1'b1);
		queue_button(8'h80, 1'b0);
		queue_tick(8'd10);
		queue_tick(8'd255);
		queue_move(16'h7FFF, 16'h8000);
		queue_button(8'h40, 1'b1);
		queue_move(16'h7FFD, 16'h8002);
		queue_move(16'h8000, 16'h7FFF);
		queue_button(8'h00, 1'b0);
		queue_button(8'h55, 1'b1);
		queue_tick(8'd30);
		queue_button(8'hAA, 1'b1);
		queue_button(8'h00, 1'b1);
		queue_move(16'h8003, 16'h7FFF);
		wait_idle();

		foreach (window_plan[i]) begin
			write_window(window_plan[i]);
			queue_random_items(PHASE_ITEMS);
			wait_idle();
		end

		// saturate the click count, then drain the window
		write_window(8'd255);
		hold_calm = 1'b1;
		queue_button(8'h00, 1'b0);
		queue_button(8'h03, 1'b1);
		repeat (SAT_PAIRS) begin
			queue_button(8'h01, 1'($urandom));
			queue_button(8'h03, 1'($urandom));
		end
		repeat (8)
			queue_tick(8'd255);
		wait_idle();
		hold_calm = 1'b0;

		if (fail_count == 0)
			$display("tb_mouse_multi_click_detector_top OK");
		else
			$display("tb_mouse_multi_click_detector_top NOT OK");
		$finish;
	end

endmodule
